// ===== rtl/core/split_quaternion_geo_exp_defines.svh =====
// ============================================================================
// split_quaternion_geo_exp_defines.svh
// Assertion macros used by the checker of the split-quaternion exponential.
// ============================================================================
`ifndef SPLIT_QUATERNION_GEO_EXP_DEFINES_SVH
`define SPLIT_QUATERNION_GEO_EXP_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define SQGE_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define SQGE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/sqge_pkg.sv =====
// ============================================================================
// sqge_pkg
// Widths, register indexes and limits of the split-quaternion exponential.
// ============================================================================
package sqge_pkg;

    // Series length and fixed-point formats.
    localparam int MAX_TERMS = 32;
    localparam int IN_W      = 16;
    localparam int FRAC      = 30;
    localparam int IN_FRAC   = 12;

    // Term and running-sum width (Q.30 values with headroom).
    localparam int CUR_W = 50;
    localparam int SUM_W = 50;

    // Term times exponent, and the sum of two such products.
    localparam int PP_W  = CUR_W + IN_W;
    localparam int ACC_W = PP_W + 1;

    // Quotient path: dividend width, reciprocal width and split point.
    localparam int DIV_W = 49;
    localparam int MR_W  = DIV_W + 1;
    localparam int SPL_W = 25;
    localparam int PRT_W = 2 * SPL_W;
    localparam int QP_W  = 2 * MR_W;

    // Six live series channels: four of the move series, two of the rotation.
    localparam int NCH   = 6;
    localparam int CH_M0 = 0;
    localparam int CH_M1 = 1;
    localparam int CH_M2 = 2;
    localparam int CH_M3 = 3;
    localparam int CH_R0 = 4;
    localparam int CH_R3 = 5;
    localparam int NPROD = 8;

    // Products of one series step: eight of the move series, two of the rotation.
    localparam int NSPROD = 10;

    // Final product of the two sums, split into halves.
    localparam int FSP_W = 25;
    localparam int FH_W  = FSP_W + 1;
    localparam int FPP_W = 2 * FH_W;
    localparam int FP_W  = 104;

    // Output format.
    localparam int OUT_W     = 40;
    localparam int OUT_SHIFT = 40;
    localparam logic [OUT_W-1:0] OUT_SAT_HI = OUT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [OUT_W-1:0] OUT_SAT_LO = OUT_W'(64'd1 << (OUT_W - 1));

    // Stream and configuration widths.
    localparam int IDATA_W    = 48;
    localparam int ODATA_W    = 4 * OUT_W;
    localparam int TERMS_W    = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_ORDER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERIES_TERMS  = 4'd1;

endpackage

// ===== rtl/core/split_quaternion_geo_exp.sv =====
// ============================================================================
// split_quaternion_geo_exp
// Product of the truncated exponentials of a move and a rotation in the
// split-quaternion algebra, fully pipelined.
// ============================================================================
// The block takes one transfer per clock unless the output stalls, and returns
// one result per input in order, through one input register, 32 series steps
// of four stages each (exponent products, rounding setup, reciprocal partial
// products, term and sum update) and four stages for the final product,
// rounding and saturation. A result held at the output stalls the whole
// pipeline, so s_tready follows m_tready while a result waits. Configuration
// is taken in any cycle and must only change while no item is in flight.
module split_quaternion_geo_exp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // move_x [15:0], move_y [31:16], rot_angle [47:32]
    input  logic [sqge_pkg::IDATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_scalar [39:0], out_i [79:40], out_j [119:80], out_k [159:120]
    output logic [sqge_pkg::ODATA_W-1:0]        m_tdata,
    // saturated [0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sqge_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sqge_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int MAX_TERMS = sqge_pkg::MAX_TERMS;
    localparam int IN_W      = sqge_pkg::IN_W;
    localparam int CUR_W     = sqge_pkg::CUR_W;
    localparam int SUM_W     = sqge_pkg::SUM_W;
    localparam int PP_W      = sqge_pkg::PP_W;
    localparam int ACC_W     = sqge_pkg::ACC_W;
    localparam int DIV_W     = sqge_pkg::DIV_W;
    localparam int MR_W      = sqge_pkg::MR_W;
    localparam int SPL_W     = sqge_pkg::SPL_W;
    localparam int PRT_W     = sqge_pkg::PRT_W;
    localparam int QP_W      = sqge_pkg::QP_W;
    localparam int NCH       = sqge_pkg::NCH;
    localparam int NPROD     = sqge_pkg::NPROD;
    localparam int NSPROD    = sqge_pkg::NSPROD;
    localparam int FSP_W     = sqge_pkg::FSP_W;
    localparam int FH_W      = sqge_pkg::FH_W;
    localparam int FPP_W     = sqge_pkg::FPP_W;
    localparam int FP_W      = sqge_pkg::FP_W;
    localparam int OUT_W     = sqge_pkg::OUT_W;
    localparam int TERMS_W   = sqge_pkg::TERMS_W;

    localparam logic signed [CUR_W-1:0] ONE = CUR_W'(64'd1 << sqge_pkg::FRAC);
    localparam logic signed [FP_W-1:0] LIM_HI = $signed(FP_W'(sqge_pkg::OUT_SAT_HI));
    localparam logic signed [FP_W-1:0] LIM_LO = -$signed(FP_W'(sqge_pkg::OUT_SAT_LO));
    localparam logic signed [FP_W-1:0] HALF_LSB =
        $signed(FP_W'(1)) <<< (sqge_pkg::OUT_SHIFT - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               product_order_reg;
    logic [TERMS_W-1:0] series_terms_reg;

    assign cfg_ready = 1'b1;

    // A write to an index outside the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_order_reg <= 1'b0;
            series_terms_reg  <= TERMS_W'(MAX_TERMS);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sqge_pkg::REG_PRODUCT_ORDER: product_order_reg <= cfg_data[0];
                sqge_pkg::REG_SERIES_TERMS:  series_terms_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves unless a result waits at the output.
    // ------------------------------------------------------------------
    logic adv;
    logic out_vld_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // Inputs and outputs of the series steps.
    logic                    vld_reg [0:MAX_TERMS];
    logic signed [IN_W-1:0]  x_reg   [0:MAX_TERMS];
    logic signed [IN_W-1:0]  y_reg   [0:MAX_TERMS];
    logic signed [IN_W-1:0]  r_reg   [0:MAX_TERMS];
    logic signed [CUR_W-1:0] cur_reg [1:MAX_TERMS][0:NCH-1];
    logic signed [SUM_W-1:0] sum_reg [1:MAX_TERMS][0:NCH-1];

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= $signed(s_tdata[IN_W-1:0]);
            y_reg[0] <= $signed(s_tdata[2*IN_W-1:IN_W]);
            r_reg[0] <= $signed(s_tdata[3*IN_W-1:2*IN_W]);
        end
    end

    // ------------------------------------------------------------------
    // Series steps. Step n multiplies the previous term by the exponent,
    // divides by n*2^12 with ties rounded away from zero, and adds the
    // new term to the sum when n is within the configured term count.
    // The move channels hold all four components; the rotation series
    // only ever has a scalar and a k part.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_TERMS; g++)
    begin : g_term
        localparam int N = g + 1;
        localparam int L = $clog2(N);
        localparam int S = DIV_W + L;
        localparam logic [127:0] TWO_S = 128'd1 << S;
        // Rounded-up reciprocal; exact floor division for dividends below 2^DIV_W.
        localparam logic [MR_W-1:0] RECIP = MR_W'((TWO_S + 128'(N) - 128'd1) / 128'(N));
        localparam logic [TERMS_W-1:0] N_CODE = TERMS_W'(N);

        logic signed [CUR_W-1:0] cur_in [0:NCH-1];
        logic signed [SUM_W-1:0] sum_in [0:NCH-1];

        // The first step starts from the constant term 1.
        if (g == 0)
        begin : g_first
            always_comb
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    if (c == sqge_pkg::CH_M0 || c == sqge_pkg::CH_R0)
                    begin
                        cur_in[c] = ONE;
                        sum_in[c] = ONE;
                    end
                    else
                    begin
                        cur_in[c] = '0;
                        sum_in[c] = '0;
                    end
                end
            end
        end
        else
        begin : g_chain
            always_comb
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    cur_in[c] = cur_reg[g][c];
                    sum_in[c] = sum_reg[g][c];
                end
            end
        end

        logic                    s1_vld_reg, s2_vld_reg, s3_vld_reg;
        logic signed [IN_W-1:0]  s1_x_reg, s1_y_reg, s1_r_reg;
        logic signed [IN_W-1:0]  s2_x_reg, s2_y_reg, s2_r_reg;
        logic signed [IN_W-1:0]  s3_x_reg, s3_y_reg, s3_r_reg;
        logic signed [SUM_W-1:0] s1_sum_reg [0:NCH-1];
        logic signed [SUM_W-1:0] s2_sum_reg [0:NCH-1];
        logic signed [SUM_W-1:0] s3_sum_reg [0:NCH-1];
        logic signed [PP_W-1:0]  s1_prod_reg [0:NSPROD-1];
        logic signed [ACC_W-1:0] s2_acc [0:NCH-1];
        logic [ACC_W-1:0]        s2_mag [0:NCH-1];
        logic [ACC_W-1:0]        s2_rnd [0:NCH-1];
        logic [DIV_W-1:0]        s2_quo_reg [0:NCH-1];
        logic [NCH-1:0]          s2_neg_reg, s3_neg_reg;
        logic [PRT_W-1:0]        s3_part_reg [0:NCH-1][0:3];
        logic [QP_W-1:0]         s4_full [0:NCH-1];
        logic [DIV_W-1:0]        s4_quo [0:NCH-1];
        logic signed [CUR_W-1:0] s4_mag [0:NCH-1];
        logic signed [CUR_W-1:0] s4_term [0:NCH-1];
        logic                    take_term;

        // Valid bits of the four stages.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                s1_vld_reg     <= 1'b0;
                s2_vld_reg     <= 1'b0;
                s3_vld_reg     <= 1'b0;
                vld_reg[g + 1] <= 1'b0;
            end
            else if (adv)
            begin
                s1_vld_reg     <= vld_reg[g];
                s2_vld_reg     <= s1_vld_reg;
                s3_vld_reg     <= s2_vld_reg;
                vld_reg[g + 1] <= s3_vld_reg;
            end
        end

        // Stage 1: products of the term with the exponent components.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s1_x_reg <= x_reg[g];
                s1_y_reg <= y_reg[g];
                s1_r_reg <= r_reg[g];
                for (int c = 0; c < NCH; c++)
                begin
                    s1_sum_reg[c] <= sum_in[c];
                end
                s1_prod_reg[0] <= PP_W'(cur_in[sqge_pkg::CH_M1]) * PP_W'(x_reg[g]);
                s1_prod_reg[1] <= PP_W'(cur_in[sqge_pkg::CH_M2]) * PP_W'(y_reg[g]);
                s1_prod_reg[2] <= PP_W'(cur_in[sqge_pkg::CH_M3]) * PP_W'(y_reg[g]);
                s1_prod_reg[3] <= PP_W'(cur_in[sqge_pkg::CH_M3]) * PP_W'(x_reg[g]);
                s1_prod_reg[4] <= PP_W'(cur_in[sqge_pkg::CH_M2]) * PP_W'(x_reg[g]);
                s1_prod_reg[5] <= PP_W'(cur_in[sqge_pkg::CH_M1]) * PP_W'(y_reg[g]);
                s1_prod_reg[6] <= PP_W'(cur_in[sqge_pkg::CH_R3]) * PP_W'(r_reg[g]);
                s1_prod_reg[7] <= PP_W'(cur_in[sqge_pkg::CH_R0]) * PP_W'(r_reg[g]);
                s1_prod_reg[8] <= PP_W'(cur_in[sqge_pkg::CH_M0]) * PP_W'(x_reg[g]);
                s1_prod_reg[9] <= PP_W'(cur_in[sqge_pkg::CH_M0]) * PP_W'(y_reg[g]);
            end
        end

        // Stage 2: algebra product, magnitude, and the rounding offset n*2^11.
        always_comb
        begin
            s2_acc[sqge_pkg::CH_M0] = ACC_W'(s1_prod_reg[0]) + ACC_W'(s1_prod_reg[1]);
            s2_acc[sqge_pkg::CH_M1] = ACC_W'(s1_prod_reg[8]) - ACC_W'(s1_prod_reg[2]);
            s2_acc[sqge_pkg::CH_M2] = ACC_W'(s1_prod_reg[9]) + ACC_W'(s1_prod_reg[3]);
            s2_acc[sqge_pkg::CH_M3] = ACC_W'(s1_prod_reg[4]) - ACC_W'(s1_prod_reg[5]);
            s2_acc[sqge_pkg::CH_R0] = ACC_W'(s1_prod_reg[6]);
            s2_acc[sqge_pkg::CH_R3] = -ACC_W'(s1_prod_reg[7]);
            for (int c = 0; c < NCH; c++)
            begin
                s2_mag[c] = s2_acc[c][ACC_W-1] ? ACC_W'(-s2_acc[c]) : ACC_W'(s2_acc[c]);
                s2_rnd[c] = s2_mag[c] + (ACC_W'(N) << (sqge_pkg::IN_FRAC - 1));
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s2_x_reg <= s1_x_reg;
                s2_y_reg <= s1_y_reg;
                s2_r_reg <= s1_r_reg;
                for (int c = 0; c < NCH; c++)
                begin
                    s2_sum_reg[c] <= s1_sum_reg[c];
                    s2_neg_reg[c] <= s2_acc[c][ACC_W-1];
                    s2_quo_reg[c] <=
                        s2_rnd[c][DIV_W+sqge_pkg::IN_FRAC-1:sqge_pkg::IN_FRAC];
                end
            end
        end

        // Stage 3: partial products of the dividend with the reciprocal of n.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s3_x_reg   <= s2_x_reg;
                s3_y_reg   <= s2_y_reg;
                s3_r_reg   <= s2_r_reg;
                s3_neg_reg <= s2_neg_reg;
                for (int c = 0; c < NCH; c++)
                begin
                    s3_sum_reg[c] <= s2_sum_reg[c];
                    s3_part_reg[c][0] <= PRT_W'(s2_quo_reg[c][SPL_W-1:0])
                                       * PRT_W'(RECIP[SPL_W-1:0]);
                    s3_part_reg[c][1] <= PRT_W'(s2_quo_reg[c][SPL_W-1:0])
                                       * PRT_W'(RECIP[MR_W-1:SPL_W]);
                    s3_part_reg[c][2] <= PRT_W'(s2_quo_reg[c][DIV_W-1:SPL_W])
                                       * PRT_W'(RECIP[SPL_W-1:0]);
                    s3_part_reg[c][3] <= PRT_W'(s2_quo_reg[c][DIV_W-1:SPL_W])
                                       * PRT_W'(RECIP[MR_W-1:SPL_W]);
                end
            end
        end

        // Stage 4: quotient, sign, and the running sum.
        assign take_term = (N_CODE <= series_terms_reg);

        always_comb
        begin
            for (int c = 0; c < NCH; c++)
            begin
                s4_full[c] = (QP_W'(s3_part_reg[c][3]) << (2 * SPL_W))
                           + (QP_W'(s3_part_reg[c][1]) << SPL_W)
                           + (QP_W'(s3_part_reg[c][2]) << SPL_W)
                           + QP_W'(s3_part_reg[c][0]);
                s4_quo[c]  = DIV_W'(s4_full[c] >> S);
                s4_mag[c]  = $signed({1'b0, s4_quo[c]});
                s4_term[c] = s3_neg_reg[c] ? -s4_mag[c] : s4_mag[c];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[g + 1] <= s3_x_reg;
                y_reg[g + 1] <= s3_y_reg;
                r_reg[g + 1] <= s3_r_reg;
                for (int c = 0; c < NCH; c++)
                begin
                    cur_reg[g + 1][c] <= s4_term[c];
                    sum_reg[g + 1][c] <= s3_sum_reg[c] + (take_term ? s4_term[c] : '0);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Final product R*M or M*R. Only the scalar and k parts of R are
    // nonzero, so eight products of r0, r3 with m0..m3 are needed, each
    // built from four half-width partial products.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] rsum [0:1];
    logic signed [FH_W-1:0]  fa_lo [0:1];
    logic signed [FH_W-1:0]  fa_hi [0:1];
    logic signed [FH_W-1:0]  fb_lo [0:3];
    logic signed [FH_W-1:0]  fb_hi [0:3];
    logic                    f1_vld_reg, f2_vld_reg, f3_vld_reg;
    logic signed [FPP_W-1:0] f1_pp_reg [0:NPROD-1][0:3];
    logic signed [FP_W-1:0]  f2_prod_reg [0:NPROD-1];
    logic signed [FP_W-1:0]  f3_comp_reg [0:3];
    logic signed [FP_W-1:0]  f4_shift [0:3];
    logic [OUT_W-1:0]        f4_val [0:3];
    logic [3:0]              f4_clip;
    logic [OUT_W-1:0]        out_reg [0:3];
    logic                    sat_reg;

    // Split each sum into an unsigned low half and a signed high half.
    always_comb
    begin
        rsum[0] = sum_reg[MAX_TERMS][sqge_pkg::CH_R0];
        rsum[1] = sum_reg[MAX_TERMS][sqge_pkg::CH_R3];
        for (int i = 0; i < 2; i++)
        begin
            fa_lo[i] = $signed({1'b0, rsum[i][FSP_W-1:0]});
            fa_hi[i] = FH_W'($signed(rsum[i][SUM_W-1:FSP_W]));
        end
        for (int j = 0; j < 4; j++)
        begin
            fb_lo[j] = $signed({1'b0, sum_reg[MAX_TERMS][j][FSP_W-1:0]});
            fb_hi[j] = FH_W'($signed(sum_reg[MAX_TERMS][j][SUM_W-1:FSP_W]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            f3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg  <= vld_reg[MAX_TERMS];
            f2_vld_reg  <= f1_vld_reg;
            f3_vld_reg  <= f2_vld_reg;
            out_vld_reg <= f3_vld_reg;
        end
    end

    // Partial products, then their sums.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 2; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    f1_pp_reg[i*4+j][0] <= FPP_W'(fa_lo[i]) * FPP_W'(fb_lo[j]);
                    f1_pp_reg[i*4+j][1] <= FPP_W'(fa_lo[i]) * FPP_W'(fb_hi[j]);
                    f1_pp_reg[i*4+j][2] <= FPP_W'(fa_hi[i]) * FPP_W'(fb_lo[j]);
                    f1_pp_reg[i*4+j][3] <= FPP_W'(fa_hi[i]) * FPP_W'(fb_hi[j]);
                end
            end
            for (int k = 0; k < NPROD; k++)
            begin
                f2_prod_reg[k] <= (FP_W'(f1_pp_reg[k][3]) <<< (2 * FSP_W))
                                + ((FP_W'(f1_pp_reg[k][1]) + FP_W'(f1_pp_reg[k][2]))
                                   <<< FSP_W)
                                + FP_W'(f1_pp_reg[k][0]);
            end
        end
    end

    // Components; the product order flips the sign of the cross terms.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f3_comp_reg[0] <= f2_prod_reg[0] - f2_prod_reg[7];
            f3_comp_reg[1] <= f2_prod_reg[1]
                            + (product_order_reg ? f2_prod_reg[6] : -f2_prod_reg[6]);
            f3_comp_reg[2] <= f2_prod_reg[2]
                            + (product_order_reg ? -f2_prod_reg[5] : f2_prod_reg[5]);
            f3_comp_reg[3] <= f2_prod_reg[3] + f2_prod_reg[4];
        end
    end

    // Round half up to Q.20 and clip to the 40-bit range.
    always_comb
    begin
        for (int o = 0; o < 4; o++)
        begin
            f4_shift[o] = (f3_comp_reg[o] + HALF_LSB) >>> sqge_pkg::OUT_SHIFT;
            if (f4_shift[o] > LIM_HI)
            begin
                f4_val[o]  = sqge_pkg::OUT_SAT_HI;
                f4_clip[o] = 1'b1;
            end
            else if (f4_shift[o] < LIM_LO)
            begin
                f4_val[o]  = sqge_pkg::OUT_SAT_LO;
                f4_clip[o] = 1'b1;
            end
            else
            begin
                f4_val[o]  = f4_shift[o][OUT_W-1:0];
                f4_clip[o] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int o = 0; o < 4; o++)
            begin
                out_reg[o] <= f4_val[o];
            end
            sat_reg <= |f4_clip;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser  = sat_reg;

endmodule

// ===== rtl/core/sqge_checker.sv =====
// ============================================================================
// sqge_checker
// Port-level checks of the split-quaternion exponential, bound to the top.
// ============================================================================
`include "split_quaternion_geo_exp_defines.svh"

module sqge_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [sqge_pkg::IDATA_W-1:0]        s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [sqge_pkg::ODATA_W-1:0]        m_tdata,
    input logic                                m_tuser,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [sqge_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [sqge_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int OUT_W = sqge_pkg::OUT_W;

    logic at_limit;

    // True when some component sits on a clipping limit.
    always_comb
    begin
        at_limit = 1'b0;
        for (int o = 0; o < 4; o++)
        begin
            if (m_tdata[o*OUT_W +: OUT_W] == sqge_pkg::OUT_SAT_HI
                || m_tdata[o*OUT_W +: OUT_W] == sqge_pkg::OUT_SAT_LO)
            begin
                at_limit = 1'b1;
            end
        end
    end

    // A stalled result keeps its data until the transfer.
    `SQGE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // A waiting result stops the input side.
    `SQGE_ASSERT_NOW(a_stall_input, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")

    // With the output register empty the pipeline always takes input.
    `SQGE_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready && cfg_ready, "not ready with empty output")

    // The clip flag only comes with a component at a limit.
    `SQGE_ASSERT_NOW(a_sat_limit, m_tvalid && m_tuser, at_limit, "clip flag without limit value")

endmodule

bind split_quaternion_geo_exp sqge_checker u_sqge_checker (.*);
